[rtl/assert_macros.svh]
// Assertion macros used by ordered_value_list.sv to check its own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on the rising clock edge, off while reset is low.
`define OVL_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("ordered_value_list check failed");

// Concurrent check on the rising clock edge, always active.
`define OVL_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("ordered_value_list check failed");

`endif

[rtl/ovl_pkg.sv]
`timescale 1ns / 1ps

package ovl_pkg;

    // List size and derived widths
    localparam int CAPACITY = 16;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    // Opcodes
    localparam logic OP_APPEND = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    // Status codes
    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_FULL      = 2'd1;
    localparam logic [1:0] STAT_EMPTY     = 2'd2;
    localparam logic [1:0] STAT_NOT_FOUND = 2'd3;

    // Command word
    typedef struct packed {
        logic               opcode;
        logic signed [31:0] value;
    } t_cmd;

    // Result word
    typedef struct packed {
        logic [1:0] status;
        logic [4:0] count;
        logic       full_res;
        logic       empty_res;
    } t_result;

    // Controller states
    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } t_state;

    // Broadcast control from the controller to every cell
    typedef struct packed {
        logic               load_cmp;
        logic               exec_rm;
        logic               exec_app;
        logic signed [31:0] value;
        logic [CNT_W-1:0]   count;
    } t_cell_ctl;

endpackage

[rtl/ordered_value_list.sv]
`timescale 1ns / 1ps
//
// Channel   Ports                     Direction  Handshake
// command   i_cmd (t_cmd)             in         i_start high while o_busy low
// result    o_result (t_result)       out        o_done high for one cycle
//
// For each command the accept edge loads the compare in every cell, and the
// next edge shifts or appends through the cell row and registers the result
// word. o_done rises at that same edge and lasts one cycle.
// o_busy is high for the one execute cycle; the next command can be taken
// in the cycle the result shows. Synchronous active-low reset empties the list.
// The receiver cannot stall; results are never held.
//
`include "assert_macros.svh"

module ordered_value_list import ovl_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    input  t_cmd    i_cmd,
    output logic    o_busy,
    output logic    o_done,
    output t_result o_result
);

    t_state             r_state;
    t_state             n_state;
    logic               r_op;
    logic signed [31:0] r_value;
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   n_count;
    logic               r_done;
    t_result            r_result;
    t_result            n_result;
    logic               w_accept;
    logic               w_found;
    t_cell_ctl          w_ctl;

    logic               w_hit [CAPACITY+1];
    logic signed [31:0] w_cell_value [CAPACITY];

    assign w_accept = i_start && (r_state == ST_IDLE);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) n_state = ST_EXEC;
            end
            ST_EXEC: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // Cell controls
    always_comb begin
        w_ctl.load_cmp = w_accept;
        w_ctl.exec_rm  = (r_state == ST_EXEC) && (r_op == OP_REMOVE);
        w_ctl.exec_app = (r_state == ST_EXEC) && (r_op == OP_APPEND)
                         && (r_count < CNT_W'(CAPACITY));
        w_ctl.value    = (r_state == ST_EXEC) ? r_value : i_cmd.value;
        w_ctl.count    = r_count;
    end

    // Cell row
    assign w_hit[0] = 1'b0;
    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            logic signed [31:0] w_next;
            if (g == CAPACITY - 1) begin : g_last
                assign w_next = w_cell_value[g];
            end else begin : g_mid
                assign w_next = w_cell_value[g+1];
            end
            ovl_cell u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_ctl        (w_ctl),
                .i_idx        (IDX_W'(g)),
                .i_next_value (w_next),
                .i_hit        (w_hit[g]),
                .o_hit        (w_hit[g+1]),
                .o_value      (w_cell_value[g])
            );
        end
    endgenerate
    assign w_found = w_hit[CAPACITY];

    // Result and new count for the executing command
    always_comb begin
        n_count = r_count;
        if (r_op == OP_APPEND) begin
            if (r_count >= CNT_W'(CAPACITY)) begin
                n_result.status = STAT_FULL;
            end else begin
                n_result.status = STAT_OK;
                n_count         = r_count + 1'b1;
            end
        end else if (r_count == '0) begin
            n_result.status = STAT_EMPTY;
        end else if (!w_found) begin
            n_result.status = STAT_NOT_FOUND;
        end else begin
            n_result.status = STAT_OK;
            n_count         = r_count - 1'b1;
        end
        n_result.count     = 5'(n_count);
        n_result.full_res  = n_count == CNT_W'(CAPACITY);
        n_result.empty_res = n_count == '0;
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= r_state == ST_EXEC;
            if (r_state == ST_EXEC) r_count <= n_count;
        end
    end

    // Command and result words
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op    <= i_cmd.opcode;
            r_value <= i_cmd.value;
        end
        if (r_state == ST_EXEC) r_result <= n_result;
    end

    assign o_busy   = r_state == ST_EXEC;
    assign o_done   = r_done;
    assign o_result = r_result;

    // Checks
    `OVL_ASSERT(a_done_after_accept, i_clk, i_rst_n, (i_start && !o_busy) |-> ##2 o_done)
    `OVL_ASSERT(a_busy_one_cycle, i_clk, i_rst_n, o_busy |=> !o_busy)
    `OVL_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= CNT_W'(CAPACITY))
    `OVL_ASSERT(a_fail_keeps_count, i_clk, i_rst_n,
                (o_done && (o_result.status != STAT_OK)) |-> $stable(r_count))

endmodule

[rtl/ovl_cell.sv]
`timescale 1ns / 1ps

module ovl_cell import ovl_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cell_ctl          i_ctl,
    input  logic [IDX_W-1:0]   i_idx,
    input  logic signed [31:0] i_next_value,
    input  logic               i_hit,
    output logic               o_hit,
    output logic signed [31:0] o_value
);

    logic signed [31:0] r_value;
    logic               r_match;
    logic               w_live;
    logic               w_tail;

    // Slot position against the current count
    assign w_live = CNT_W'(i_idx) < i_ctl.count;
    assign w_tail = CNT_W'(i_idx) == i_ctl.count;

    // Compare on accept; only live slots can match
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match <= 1'b0;
        end else if (i_ctl.load_cmp) begin
            r_match <= w_live && (r_value == i_ctl.value);
        end
    end

    // Shift left from the first hit onward, or take the appended word at the tail
    always_ff @(posedge i_clk) begin
        if (i_ctl.exec_rm && (i_hit || r_match)) begin
            r_value <= i_next_value;
        end else if (i_ctl.exec_app && w_tail) begin
            r_value <= i_ctl.value;
        end
    end

    // Hit chain toward the tail
    assign o_hit   = i_hit | r_match;
    assign o_value = r_value;

endmodule
